[hw/rtl/crce_pkg.sv]
// ----------------------------------------------------------------------------
// crce_pkg
// Shared types, constants and CRC helper functions for the CRC-16 engine.
// ----------------------------------------------------------------------------
package crce_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned CrcW  = 16;

  localparam logic [CrcW-1:0] CrcInit   = 16'hFFFF;
  localparam logic [CrcW-1:0] PolyReset = 16'h0025;

  // One message byte together with its end-of-message flag.
  typedef struct packed {
    logic             last;
    logic [DataW-1:0] data;
  } byte_item_t;

  function automatic logic [CrcW-1:0] reverse16(input logic [CrcW-1:0] v);
    logic [CrcW-1:0] r;
    for (int k = 0; k < CrcW; k++) begin
      r[k] = v[CrcW-1-k];
    end
    return r;
  endfunction

  // Absorb one byte, least significant bit first, into the MSB-first register.
  function automatic logic [CrcW-1:0] absorb(input logic [CrcW-1:0] crc,
                                             input logic [DataW-1:0] b,
                                             input logic [CrcW-1:0] poly);
    logic [CrcW-1:0] r;
    r = crc;
    for (int k = 0; k < DataW; k++) begin
      if (r[CrcW-1] ^ b[k]) begin
        r = {r[CrcW-2:0], 1'b0} ^ poly;
      end else begin
        r = {r[CrcW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

[hw/rtl/crc16_reflected_engine.sv]
// ----------------------------------------------------------------------------
// crc16_reflected_engine
// Byte-stream CRC-16 with reflected input and output and a programmable
// polynomial.
// ----------------------------------------------------------------------------
// The engine takes one message byte per transfer, with tlast marking the final
// byte, and returns one 16-bit CRC transfer per message. It sustains one byte
// per clock while no last byte stalls: each byte waits in the input register,
// then the eight-bit CRC update is applied combinationally on its way into
// the CRC register. The result register is loaded as the last byte moves out
// of the input register.
// The result register decouples the output, so bytes keep flowing while a CRC
// waits to be taken; only a last byte stalls, and only while the previous CRC
// is still pending. The user must write the polynomial register (reset 0x0025)
// through cfg_we_i only while no byte waits in the input register; the block
// itself does not enforce this. A new polynomial applies from the next byte,
// even in the middle of a message.
module crc16_reflected_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,   // poly
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [15:0] crc_value
);
  import crce_pkg::*;

  byte_item_t in_item;
  byte_item_t stage_item;
  logic       stage_valid;
  logic       stage_take;

  assign in_item.data = s_axis_tdata;
  assign in_item.last = s_axis_tlast;

  crce_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .stage_valid_o(stage_valid),
    .stage_take_i (stage_take),
    .stage_item_o (stage_item)
  );

  crce_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .stage_valid_i(stage_valid),
    .stage_take_o (stage_take),
    .stage_item_i (stage_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_crc_o    (m_axis_tdata)
  );

endmodule

[hw/rtl/crce_in_stage.sv]
// ----------------------------------------------------------------------------
// crce_in_stage
// Input register: captures one byte transfer and holds it until the core
// takes it.
// ----------------------------------------------------------------------------
module crce_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  crce_pkg::byte_item_t in_item_i,
  output logic                stage_valid_o,
  input  logic                stage_take_i,
  output crce_pkg::byte_item_t stage_item_o
);
  import crce_pkg::*;

  logic       vld_q, vld_d;
  byte_item_t item_q;

  // The stage frees up in the same cycle its content moves on.
  assign in_ready_o = !vld_q || stage_take_i;

  always_comb begin
    vld_d = vld_q;
    if (in_ready_o) begin
      vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign stage_valid_o = vld_q;
  assign stage_item_o  = item_q;

endmodule

[hw/rtl/crce_core.sv]
// ----------------------------------------------------------------------------
// crce_core
// CRC register, polynomial register, byte update logic and result register.
// ----------------------------------------------------------------------------
module crce_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 stage_valid_i,
  output logic                 stage_take_o,
  input  crce_pkg::byte_item_t stage_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [15:0]          out_crc_o
);
  import crce_pkg::*;

  logic [CrcW-1:0] poly_q;
  logic [CrcW-1:0] crc_q, crc_d;
  logic [CrcW-1:0] crc_next;
  logic            out_vld_q, out_vld_d;
  logic [CrcW-1:0] out_crc_q;
  logic            emit;

  // A plain byte always moves on; a last byte needs a free result slot.
  assign stage_take_o = stage_valid_i &&
                        (!stage_item_i.last || !out_vld_q || out_ready_i);
  assign emit         = stage_take_o && stage_item_i.last;
  assign crc_next     = absorb(crc_q, stage_item_i.data, poly_q);

  always_comb begin
    crc_d = crc_q;
    if (stage_take_o) begin
      crc_d = stage_item_i.last ? CrcInit : crc_next;
    end
    out_vld_d = out_vld_q;
    if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (emit) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q    <= PolyReset;
      crc_q     <= CrcInit;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        poly_q <= cfg_wdata_i;
      end
      crc_q     <= crc_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_crc_q <= reverse16(~crc_next);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_crc_o   = out_crc_q;

endmodule

[hw/rtl/crce_checker.sv]
// ----------------------------------------------------------------------------
// crce_checker
// Port-level checks for the CRC-16 engine, bound to the top level.
// ----------------------------------------------------------------------------
module crce_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // A pending CRC stays put until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("pending CRC transfer changed before it was taken");

  // With no result pending the input side never stalls.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the result slot was empty");

  // Every accepted last byte is followed by a pending result.
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |-> ##2 m_axis_tvalid)
    else $error("no CRC result after an accepted last byte");

  // A new result only ever follows a matching accepted last byte.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("CRC result without a matching last byte");

endmodule

bind crc16_reflected_engine crce_checker u_crce_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
